// ===== rtl/svpwm_pkg.sv =====
// Shared types and constants for the SVPWM duty calculator.
`default_nettype none
package svpwm_pkg;

  localparam int VOLT_BITS  = 16;
  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CEILING = 2'd2;

  localparam logic                 MODE_RESET    = 1'b0;
  localparam logic [DUTY_BITS-1:0] FLOOR_RESET   = 16'd3277;
  localparam logic [DUTY_BITS-1:0] CEILING_RESET = 16'd62259;
  localparam logic [DUTY_BITS-1:0] HALF_DUTY     = 16'h8000;

  localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
  localparam logic [31:0]        RECIP_THREE    = 32'hAAAAAAAB;

  typedef struct packed {
    logic signed [VOLT_BITS-1:0]  volt_d;
    logic signed [VOLT_BITS-1:0]  volt_q;
    logic signed [ANGLE_BITS-1:0] angle_sine;
    logic signed [ANGLE_BITS-1:0] angle_cosine;
    logic        [VOLT_BITS-1:0]  bus_volts;
  } svpwm_in_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] phase_a_duty;
    logic [DUTY_BITS-1:0] phase_b_duty;
    logic [DUTY_BITS-1:0] phase_c_duty;
  } svpwm_out_t;

endpackage
`default_nettype wire

// ===== rtl/svpwm_pdiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
`default_nettype none
module svpwm_pdiv #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 31,
  parameter int Q_W   = 16,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]    rem_r   [Q_W];
  logic [CW-1:0]    rem_nxt [Q_W];
  logic [DEN_W-1:0] den_r   [Q_W];
  logic [Q_W-1:0]   quo_r   [Q_W];
  logic [Q_W-1:0]   quo_nxt [Q_W];
  logic [TAG_W-1:0] tag_r   [Q_W];
  logic [Q_W-1:0]   vld_r;

  logic [CW-1:0]    src_rem [Q_W];
  logic [DEN_W-1:0] src_den [Q_W];
  logic [Q_W-1:0]   src_quo [Q_W];
  logic [CW-1:0]    trial   [Q_W];

  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      if (j == 0) begin
        src_rem[j] = CW'(in_num);
        src_den[j] = in_den;
        src_quo[j] = '0;
      end else begin
        src_rem[j] = rem_r[j-1];
        src_den[j] = den_r[j-1];
        src_quo[j] = quo_r[j-1];
      end
      trial[j] = CW'(src_den[j]) << (Q_W - 1 - j);
      if (src_rem[j] >= trial[j]) begin
        rem_nxt[j] = src_rem[j] - trial[j];
        quo_nxt[j] = src_quo[j] | (Q_W'(1) << (Q_W - 1 - j));
      end else begin
        rem_nxt[j] = src_rem[j];
        quo_nxt[j] = src_quo[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < Q_W; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
        den_r[j] <= src_den[j];
        tag_r[j] <= (j == 0) ? in_tag : tag_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule
`default_nettype wire

// ===== rtl/svpwm_duty_calculator_top.sv =====
// Top level of the SVPWM duty calculator: transforms, zero sequence, duty scaling.
// Accepts one item per clock cycle while the output side does not stall. The depth of
// the pipeline is set mostly by two chained
// restoring dividers, one quotient bit per stage: the 16-bit third-harmonic ratio and
// the 17-bit division of each phase by the bus voltage; the division by three is a
// reciprocal multiplication in one stage. A stall at the output freezes the whole
// pipeline; nothing is dropped.
`default_nettype none
module svpwm_duty_calculator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  svpwm_pkg::svpwm_in_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output svpwm_pkg::svpwm_out_t             out_data,
  input  logic                              cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import svpwm_pkg::*;

  typedef struct packed {
    logic signed [33:0] u0;
    logic signed [33:0] u1;
    logic signed [33:0] u2;
    logic signed [35:0] vm0;
    logic signed [35:0] vm1;
    logic signed [35:0] vm2;
    logic [15:0]        bus;
    logic               nz;
    logic               neg;
  } svpwm_tag_t;

  localparam int TAG_W = $bits(svpwm_tag_t);

  logic                 mode_r;
  logic [DUTY_BITS-1:0] floor_r;
  logic [DUTY_BITS-1:0] ceil_r;
  logic                 en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RESET;
      floor_r <= FLOOR_RESET;
      ceil_r  <= CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE:    mode_r  <= cfg_wdata[0];
        CFG_IDX_FLOOR:   floor_r <= cfg_wdata;
        CFG_IDX_CEILING: ceil_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stages 1..9: transforms, min/max, normalization, ratio operands
  logic [8:0]         pre_vld_r;
  svpwm_in_t          s1_d_r;
  logic signed [31:0] s2_dc_r, s2_qs_r, s2_ds_r, s2_qc_r;
  logic [15:0]        s2_bus_r, s3_bus_r, s4_bus_r, s5_bus_r, s6_bus_r, s7_bus_r, s8_bus_r;
  logic signed [32:0] s3_alpha_r, s3_beta_r, s4_alpha_r, s4_beta_r;
  logic signed [48:0] s4_tb_r;
  logic signed [33:0] s5_u_r [3];
  logic signed [33:0] s6_u_r [3];
  logic signed [33:0] s7_u_r [3];
  logic signed [33:0] s8_u_r [3];
  logic [31:0]        s5_ma_r, s5_mb_r, s6_ma_r, s6_mb_r;
  logic signed [34:0] s6_msum_r;
  logic [4:0]         s6_sh_r;
  logic signed [35:0] s7_vm_r [3];
  logic signed [35:0] s8_vm_r [3];
  logic [14:0]        s7_a_r, s7_b_r;
  logic               s7_nz_r, s8_nz_r;
  logic [29:0]        s8_a2_r, s8_b2_r;
  svpwm_tag_t         s9_tag_r;
  logic [45:0]        s9_num_r;
  logic [30:0]        s9_den_r;

  logic signed [48:0] s5_a14_nxt, s5_sum1_nxt, s5_sum2_nxt;
  logic signed [33:0] s6_mx_nxt, s6_mn_nxt;
  logic [31:0]        s6_or_nxt;
  logic [5:0]         s6_bl_nxt;
  logic [32:0]        s9_n_nxt;
  logic [31:0]        s9_mag_nxt;

  always_comb begin
    s5_a14_nxt  = 49'(s4_alpha_r) <<< 14;
    s5_sum1_nxt = s4_tb_r - s5_a14_nxt + 49'sd16384;
    s5_sum2_nxt = -s5_a14_nxt - s4_tb_r + 49'sd16384;

    s6_mx_nxt = s5_u_r[0];
    s6_mn_nxt = s5_u_r[0];
    for (int i = 1; i < 3; i++) begin
      if (s5_u_r[i] > s6_mx_nxt) s6_mx_nxt = s5_u_r[i];
      if (s5_u_r[i] < s6_mn_nxt) s6_mn_nxt = s5_u_r[i];
    end
    s6_or_nxt = s5_ma_r | s5_mb_r;
    s6_bl_nxt = '0;
    for (int i = 0; i < 32; i++) begin
      if (s6_or_nxt[i]) s6_bl_nxt = 6'(i + 1);
    end

    s9_n_nxt   = {3'b0, s8_a2_r} - 33'd3 * {3'b0, s8_b2_r};
    s9_mag_nxt = s9_n_nxt[32] ? 32'(-s9_n_nxt) : s9_n_nxt[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= '0;
    end else if (en) begin
      pre_vld_r <= {pre_vld_r[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r <= in_data;

      s2_dc_r  <= s1_d_r.volt_d * s1_d_r.angle_cosine;
      s2_qs_r  <= s1_d_r.volt_q * s1_d_r.angle_sine;
      s2_ds_r  <= s1_d_r.volt_d * s1_d_r.angle_sine;
      s2_qc_r  <= s1_d_r.volt_q * s1_d_r.angle_cosine;
      s2_bus_r <= s1_d_r.bus_volts;

      s3_alpha_r <= 33'(s2_dc_r) - 33'(s2_qs_r);
      s3_beta_r  <= 33'(s2_ds_r) + 33'(s2_qc_r);
      s3_bus_r   <= s2_bus_r;

      s4_tb_r    <= 49'(s3_beta_r) * 49'(SQRT3_HALF_Q15);
      s4_alpha_r <= s3_alpha_r;
      s4_beta_r  <= s3_beta_r;
      s4_bus_r   <= s3_bus_r;

      s5_u_r[0] <= 34'(s4_alpha_r);
      s5_u_r[1] <= s5_sum1_nxt[48:15];
      s5_u_r[2] <= s5_sum2_nxt[48:15];
      s5_ma_r   <= 32'(s4_alpha_r[32] ? -s4_alpha_r : s4_alpha_r);
      s5_mb_r   <= 32'(s4_beta_r[32] ? -s4_beta_r : s4_beta_r);
      s5_bus_r  <= s4_bus_r;

      s6_u_r    <= s5_u_r;
      s6_msum_r <= 35'(s6_mx_nxt) + 35'(s6_mn_nxt);
      s6_sh_r   <= (s6_bl_nxt > 6'd15) ? 5'(s6_bl_nxt - 6'd15) : 5'd0;
      s6_ma_r   <= s5_ma_r;
      s6_mb_r   <= s5_mb_r;
      s6_bus_r  <= s5_bus_r;

      for (int i = 0; i < 3; i++) begin
        s7_vm_r[i] <= (36'(s6_u_r[i]) <<< 1) - 36'(s6_msum_r);
      end
      s7_u_r   <= s6_u_r;
      s7_a_r   <= 15'(s6_ma_r >> s6_sh_r);
      s7_b_r   <= 15'(s6_mb_r >> s6_sh_r);
      s7_nz_r  <= |(s6_ma_r | s6_mb_r);
      s7_bus_r <= s6_bus_r;

      s8_a2_r  <= 30'(s7_a_r) * 30'(s7_a_r);
      s8_b2_r  <= 30'(s7_b_r) * 30'(s7_b_r);
      s8_u_r   <= s7_u_r;
      s8_vm_r  <= s7_vm_r;
      s8_nz_r  <= s7_nz_r;
      s8_bus_r <= s7_bus_r;

      s9_tag_r.u0  <= s8_u_r[0];
      s9_tag_r.u1  <= s8_u_r[1];
      s9_tag_r.u2  <= s8_u_r[2];
      s9_tag_r.vm0 <= s8_vm_r[0];
      s9_tag_r.vm1 <= s8_vm_r[1];
      s9_tag_r.vm2 <= s8_vm_r[2];
      s9_tag_r.bus <= s8_bus_r;
      s9_tag_r.nz  <= s8_nz_r;
      s9_tag_r.neg <= s9_n_nxt[32];
      s9_num_r     <= {s9_mag_nxt, 14'b0};
      s9_den_r     <= 31'(s8_a2_r) + 31'(s8_b2_r);
    end
  end

  // third-harmonic ratio
  logic             rdiv_vld;
  logic [15:0]      rdiv_quo;
  logic [TAG_W-1:0] rdiv_tag;

  svpwm_pdiv #(.NUM_W(46), .DEN_W(31), .Q_W(16), .TAG_W(TAG_W)) u_rdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (pre_vld_r[8]),
    .in_num   (s9_num_r),
    .in_den   (s9_den_r),
    .in_tag   (s9_tag_r),
    .out_valid(rdiv_vld),
    .out_quo  (rdiv_quo),
    .out_tag  (rdiv_tag)
  );

  // stages 10..12: signed ratio, product with alpha, magnitude for division by three
  logic [2:0]         mid_vld_r;
  svpwm_tag_t         s10_tag_r, s11_tag_r, s12_tag_r;
  svpwm_tag_t         s12_tag_nxt;
  logic signed [16:0] s10_r_r;
  logic signed [50:0] s11_p_r;
  logic [31:0]        s12_x_r;
  logic [50:0]        s12_pm_nxt;

  always_comb begin
    s12_pm_nxt      = s11_p_r[50] ? 51'(-s11_p_r) : 51'(s11_p_r);
    s12_tag_nxt     = s11_tag_r;
    s12_tag_nxt.neg = s11_p_r[50];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= '0;
    end else if (en) begin
      mid_vld_r <= {mid_vld_r[1:0], rdiv_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_tag_r <= svpwm_tag_t'(rdiv_tag);
      s10_r_r   <= s10_tag_nxt_neg(rdiv_tag) ? -17'(rdiv_quo) : 17'(rdiv_quo);

      s11_tag_r <= s10_tag_r;
      s11_p_r   <= 51'(s10_tag_r.u0) * 51'(s10_r_r);

      s12_tag_r <= s12_tag_nxt;
      s12_x_r   <= s12_pm_nxt[46:15];
    end
  end

  function automatic logic s10_tag_nxt_neg(input logic [TAG_W-1:0] t);
    svpwm_tag_t tt;
    tt = svpwm_tag_t'(t);
    return tt.neg;
  endfunction

  // division by three: multiply by the reciprocal, keep the upper bits
  logic             zq_vld_r;
  svpwm_tag_t       zq_tag_r;
  logic [30:0]      zq_quo_r;
  logic [63:0]      zq_prod_nxt;
  logic             zdiv_vld;
  logic [31:0]      zdiv_quo;
  logic [TAG_W-1:0] zdiv_tag;

  always_comb begin
    zq_prod_nxt = 64'(s12_x_r) * 64'(RECIP_THREE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zq_vld_r <= 1'b0;
    end else if (en) begin
      zq_vld_r <= mid_vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zq_tag_r <= s12_tag_r;
      zq_quo_r <= zq_prod_nxt[63:33];
    end
  end

  assign zdiv_vld = zq_vld_r;
  assign zdiv_quo = {1'b0, zq_quo_r};
  assign zdiv_tag = zq_tag_r;

  // stages 14..15: zero-sequence add, mode select, saturation to bus range
  logic [1:0]         post_vld_r;
  svpwm_tag_t         zt;
  logic signed [32:0] z_nxt;
  logic signed [35:0] v1_nxt [3];
  logic signed [35:0] vm_nxt [3];
  logic signed [33:0] u_nxt  [3];
  logic signed [35:0] s13_v_r [3];
  logic [15:0]        s13_bus_r;
  logic signed [36:0] vx_nxt [3];
  logic signed [36:0] lim_nxt;
  logic [32:0]        mag_nxt [3];
  logic [32:0]        s14_num_r [3];
  logic [2:0]         s14_neg_r;
  logic [15:0]        s14_bus_r;

  always_comb begin
    zt        = svpwm_tag_t'(zdiv_tag);
    u_nxt[0]  = zt.u0;
    u_nxt[1]  = zt.u1;
    u_nxt[2]  = zt.u2;
    vm_nxt[0] = zt.vm0;
    vm_nxt[1] = zt.vm1;
    vm_nxt[2] = zt.vm2;
    if (!zt.nz) begin
      z_nxt = '0;
    end else if (zt.neg) begin
      z_nxt = 33'(zdiv_quo);
    end else begin
      z_nxt = -33'(zdiv_quo);
    end
    for (int i = 0; i < 3; i++) begin
      v1_nxt[i] = (36'(u_nxt[i]) + 36'(z_nxt)) <<< 1;
    end

    lim_nxt = $signed({5'b0, s13_bus_r, 16'b0});
    for (int i = 0; i < 3; i++) begin
      vx_nxt[i] = 37'(s13_v_r[i]);
      if (vx_nxt[i] > lim_nxt || vx_nxt[i] < -lim_nxt) begin
        mag_nxt[i] = lim_nxt[32:0];
      end else if (vx_nxt[i][36]) begin
        mag_nxt[i] = 33'(-vx_nxt[i]);
      end else begin
        mag_nxt[i] = vx_nxt[i][32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_vld_r <= '0;
    end else if (en) begin
      post_vld_r <= {post_vld_r[0], zdiv_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s13_v_r[i]   <= mode_r ? v1_nxt[i] : vm_nxt[i];
        s14_num_r[i] <= mag_nxt[i];
        s14_neg_r[i] <= vx_nxt[i][36];
      end
      s13_bus_r <= zt.bus;
      s14_bus_r <= s13_bus_r;
    end
  end

  // per-phase division by the bus voltage
  logic        ddiv_vld;
  logic [16:0] ddiv_quo [3];
  logic [1:0]  ddiv_tag_a;
  logic        ddiv_neg_b, ddiv_neg_c;

  svpwm_pdiv #(.NUM_W(33), .DEN_W(16), .Q_W(17), .TAG_W(2)) u_ddiv_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (post_vld_r[1]),
    .in_num   (s14_num_r[0]),
    .in_den   (s14_bus_r),
    .in_tag   ({s14_bus_r == 16'd0, s14_neg_r[0]}),
    .out_valid(ddiv_vld),
    .out_quo  (ddiv_quo[0]),
    .out_tag  (ddiv_tag_a)
  );

  svpwm_pdiv #(.NUM_W(33), .DEN_W(16), .Q_W(17), .TAG_W(1)) u_ddiv_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (post_vld_r[1]),
    .in_num   (s14_num_r[1]),
    .in_den   (s14_bus_r),
    .in_tag   (s14_neg_r[1]),
    .out_valid(),
    .out_quo  (ddiv_quo[1]),
    .out_tag  (ddiv_neg_b)
  );

  svpwm_pdiv #(.NUM_W(33), .DEN_W(16), .Q_W(17), .TAG_W(1)) u_ddiv_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (post_vld_r[1]),
    .in_num   (s14_num_r[2]),
    .in_den   (s14_bus_r),
    .in_tag   (s14_neg_r[2]),
    .out_valid(),
    .out_quo  (ddiv_quo[2]),
    .out_tag  (ddiv_neg_c)
  );

  // last two stages: offset by half, apply limits or force half duty on a zero bus, output register
  logic               s15_vld_r;
  logic               s15_bz_r;
  logic signed [18:0] s15_raw_r [3];
  logic [2:0]         neg_nxt;
  logic signed [17:0] off_nxt [3];
  logic signed [18:0] lo_nxt, hi_nxt, d_nxt [3];
  svpwm_out_t         out_data_r;
  svpwm_out_t         out_nxt;

  always_comb begin
    neg_nxt = {ddiv_neg_c, ddiv_neg_b, ddiv_tag_a[0]};
    for (int i = 0; i < 3; i++) begin
      off_nxt[i] = neg_nxt[i] ? -18'(ddiv_quo[i]) : 18'(ddiv_quo[i]);
    end

    lo_nxt = $signed({3'b0, floor_r});
    hi_nxt = $signed({3'b0, ceil_r});
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = s15_raw_r[i];
      if (d_nxt[i] < lo_nxt) d_nxt[i] = lo_nxt;
      if (d_nxt[i] > hi_nxt) d_nxt[i] = hi_nxt;
    end
    if (s15_bz_r) begin
      out_nxt = '{HALF_DUTY, HALF_DUTY, HALF_DUTY};
    end else begin
      out_nxt.phase_a_duty = d_nxt[0][15:0];
      out_nxt.phase_b_duty = d_nxt[1][15:0];
      out_nxt.phase_c_duty = d_nxt[2][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s15_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s15_vld_r   <= ddiv_vld;
      out_valid_r <= s15_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s15_raw_r[i] <= 19'sd32768 + 19'(off_nxt[i]);
      end
      s15_bz_r   <= ddiv_tag_a[1];
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/svpwm_chk.sv =====
// Port-level checker for the SVPWM duty calculator, bound to the top level.
`default_nettype none
module svpwm_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input svpwm_pkg::svpwm_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

endmodule

bind svpwm_duty_calculator_top svpwm_chk u_svpwm_chk (.*);
`default_nettype wire
